[rtl/lmss_pkg.sv]
// ----------------------------------------------------------------------------
// lmss_pkg: shared types and constants of the LED matrix stopwatch scanner
// Holds the register map, the run-mode codes, the result record and the
// 3x5 digit font used to redraw the row patterns.
// ----------------------------------------------------------------------------
`default_nettype none

package lmss_pkg;

  // matrix geometry
  localparam int unsigned Rows    = 8;
  localparam int unsigned RowIdxW = $clog2(Rows);

  // configuration register map
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegScanDivider  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegCountDivider = 1'd1;

  // register reset values
  localparam logic [15:0] ScanDividerRst  = 16'd2000;
  localparam logic [7:0]  CountDividerRst = 8'd100;
  localparam logic [Rows-1:0] RowRingRst  = 8'hFE;

  // decimal digit limit
  localparam logic [3:0] DigitTop = 4'd10;

  // run mode, encoded as it appears on the port
  typedef enum logic [1:0] {
    ModeIdle  = 2'd0,
    ModeRun   = 2'd1,
    ModePause = 2'd2
  } mode_e;

  // one result transaction
  typedef struct packed {
    logic [Rows-1:0] row_drive;
    logic [7:0]      column_data;
    logic [3:0]      ones_digit;
    logic [3:0]      tens_digit;
    logic [1:0]      run_mode;
  } result_t;

  // one glyph: a nibble per row, row 0 in the low nibble
  typedef logic [Rows-1:0][3:0] glyph_t;

  // 3x5 digit font, digits out of range show as zero
  function automatic glyph_t glyph(input logic [3:0] digit);
    glyph_t g;
    case (digit)
      4'd0:    g = 32'h0075_5570;
      4'd1:    g = 32'h0011_1110;
      4'd2:    g = 32'h0074_7170;
      4'd3:    g = 32'h0071_7170;
      4'd4:    g = 32'h0011_7550;
      4'd5:    g = 32'h0071_7470;
      4'd6:    g = 32'h0075_7470;
      4'd7:    g = 32'h0011_1170;
      4'd8:    g = 32'h0075_7570;
      4'd9:    g = 32'h0071_7570;
      default: g = 32'h0075_5570;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

[rtl/led_matrix_stopwatch_scanner.sv]
// An accepted tick's result is registered in the main entry, or skid if main is held.
// Throughput: one tick per cycle while in_stall_o is low; the whole update is a
// single pass of logic between the state registers and the output register.
// A two-entry output stage (main plus skid) keeps ticks flowing while a result waits.
// Reset: asynchronous, active low; counters, digits and patterns clear, the row
// select returns to 0xFE, mode goes idle and dividers return to 2000 and 100.
// ----------------------------------------------------------------------------
// led_matrix_stopwatch_scanner: two-digit stopwatch with 8x8 matrix scan
// Prescales input ticks into row scan steps and count steps, keeps a
// decimal count, redraws the row patterns and samples the two buttons.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_stopwatch_scanner (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration writes
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [lmss_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [lmss_pkg::CfgDataW-1:0]  cfg_data_i,
  // tick input
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic                           start_pressed_i,
  input  wire logic                           toggle_pressed_i,
  // result output
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic [lmss_pkg::Rows-1:0]      row_drive_o,
  output      logic [7:0]                     column_data_o,
  output      logic [3:0]                     ones_digit_o,
  output      logic [3:0]                     tens_digit_o,
  output      logic [1:0]                     run_mode_o
);

  import lmss_pkg::*;

  // configuration registers
  logic [15:0] scan_div_q;
  logic [7:0]  cnt_div_q;

  // stopwatch and scan state
  logic [15:0]         fast_q, fast_d;
  logic [7:0]          slow_q, slow_d;
  logic [Rows-1:0]     ring_q, ring_d;
  logic [RowIdxW-1:0]  scan_idx_q, scan_idx_d;
  logic [7:0]          col_q, col_d;
  logic [7:0]          pat_q [Rows];
  logic [7:0]          pat_d [Rows];
  logic [3:0]          ones_q, ones_d;
  logic [3:0]          tens_q, tens_d;
  mode_e               mode_q, mode_d;

  // output stage
  logic    out_vld_q, skid_vld_q;
  result_t out_q, skid_q;
  result_t res;

  logic        in_acc, out_take;
  logic [16:0] fast_sum;
  logic [8:0]  slow_sum;
  logic        scan_hit, slow_hit;
  logic [3:0]  ones_inc, tens_inc;
  glyph_t      glyph_lo, glyph_hi;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_vld_q;
  assign in_acc      = in_valid_i && !skid_vld_q;
  assign out_take    = out_vld_q && !out_stall_i;

  // configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_div_q <= ScanDividerRst;
      cnt_div_q  <= CountDividerRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegScanDivider:  scan_div_q <= cfg_data_i;
        RegCountDivider: cnt_div_q  <= cfg_data_i[7:0];
        default:         ;
      endcase
    end
  end

  // prescalers
  always_comb begin
    fast_sum = {1'b0, fast_q} + 17'd1;
    scan_hit = fast_sum >= {1'b0, scan_div_q};
    slow_sum = {1'b0, slow_q} + 9'd1;
    slow_hit = scan_hit && (slow_sum >= {1'b0, cnt_div_q});
  end

  // row scan and digit update for one tick
  always_comb begin
    fast_d     = fast_q;
    slow_d     = slow_q;
    ring_d     = ring_q;
    scan_idx_d = scan_idx_q;
    col_d      = col_q;
    pat_d      = pat_q;
    ones_d     = ones_q;
    tens_d     = tens_q;
    mode_d     = mode_q;

    // decimal increment, only used on a count step
    ones_inc = (mode_q == ModeRun) ? ones_q + 4'd1 : ones_q;
    tens_inc = tens_q;
    if (ones_inc >= DigitTop) begin
      ones_inc = 4'd0;
      tens_inc = tens_q + 4'd1;
    end
    if (tens_inc >= DigitTop) begin
      tens_inc = 4'd0;
    end
    glyph_lo = glyph(ones_inc);
    glyph_hi = glyph(tens_inc);

    if (scan_hit) begin
      fast_d     = '0;
      ring_d     = {ring_q[Rows-2:0], ring_q[Rows-1]};
      scan_idx_d = scan_idx_q + RowIdxW'(1);
      // latch uses the patterns from before any redraw
      col_d      = pat_q[scan_idx_d];
      slow_d     = slow_sum[7:0];
      if (slow_hit) begin
        slow_d = '0;
        ones_d = ones_inc;
        tens_d = tens_inc;
        for (int r = 0; r < Rows; r++) begin
          pat_d[r] = {glyph_hi[r], glyph_lo[r]};
        end
        // start first, then toggle sees the updated mode
        if (start_pressed_i) begin
          mode_d = ModeRun;
        end
        if (toggle_pressed_i) begin
          mode_d = (mode_d == ModePause) ? ModeRun : ModePause;
        end
      end
    end else begin
      fast_d = fast_sum[15:0];
    end
  end

  // state registers, advanced once per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q     <= '0;
      slow_q     <= '0;
      ring_q     <= RowRingRst;
      scan_idx_q <= '0;
      col_q      <= '0;
      for (int r = 0; r < Rows; r++) begin
        pat_q[r] <= '0;
      end
      ones_q     <= '0;
      tens_q     <= '0;
      mode_q     <= ModeIdle;
    end else if (in_acc) begin
      fast_q     <= fast_d;
      slow_q     <= slow_d;
      ring_q     <= ring_d;
      scan_idx_q <= scan_idx_d;
      col_q      <= col_d;
      pat_q      <= pat_d;
      ones_q     <= ones_d;
      tens_q     <= tens_d;
      mode_q     <= mode_d;
    end
  end

  // result record after the update
  always_comb begin
    res.row_drive   = ring_d;
    res.column_data = col_d;
    res.ones_digit  = ones_d;
    res.tens_digit  = tens_d;
    res.run_mode    = mode_d;
  end

  // output stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || out_take) begin
        out_vld_q  <= skid_vld_q || in_acc;
        skid_vld_q <= 1'b0;
      end else if (in_acc) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  // output stage payload
  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_take) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res;
      end
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign row_drive_o   = out_q.row_drive;
  assign column_data_o = out_q.column_data;
  assign ones_digit_o  = out_q.ones_digit;
  assign tens_digit_o  = out_q.tens_digit;
  assign run_mode_o    = out_q.run_mode;

`ifndef SYNTHESIS
  // exactly one row is driven low at all times
  a_ring_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(~ring_q))
    else $error("row select is not one-hot active-low");

  // row select and scan index move together
  a_ring_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_q == ~(Rows'(1) << scan_idx_q))
    else $error("row select out of step with scan index");

  // digits stay decimal
  a_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ones_q < DigitTop) && (tens_q < DigitTop))
    else $error("count digit out of decimal range");

  // skid entry is only used behind a full main entry
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry holds data while output is empty");
`endif

endmodule

`default_nettype wire
